### hdl/mpdq_pkg.sv
// Shared types and constants for the masked priority dispatch queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mpdq_pkg;

  localparam int unsigned PrioW       = 3;
  localparam int unsigned SvcW        = 5;
  localparam int unsigned TagW        = 6;
  localparam int unsigned SvcIdxW     = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned NumServices = 5;
  localparam int unsigned DefDepth    = 16;

  localparam logic ReqEnqueue  = 1'b0;
  localparam logic ReqDispatch = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_QUEUED     = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_NO_MATCH   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request and slot compare vectors
    logic execute;  // shift slots, update count, register result
  } cmd_t;

endpackage

### hdl/mpdq_ctrl.sv
// Controller FSM for the masked priority dispatch queue.
// Depends on mpdq_pkg.
`timescale 1ns / 1ps

module mpdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output mpdq_pkg::cmd_t cmd_o
);
  import mpdq_pkg::*;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    unique case (state_q)
      S_IDLE: cmd_o.capture = start;
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        busy          = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.execute;
    end
  end

  assign done_o = done_q;

endmodule

### hdl/mpdq_dpath.sv
// Datapath: slot row, per-slot compares, insert/remove shifting, result regs.
// Depends on mpdq_pkg.
`timescale 1ns / 1ps

module mpdq_dpath #(
  parameter int unsigned QUEUE_DEPTH = mpdq_pkg::DefDepth,
  parameter int unsigned LvlW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpdq_pkg::cmd_t                cmd_i,
  input  logic                          req_type_i,
  input  logic [mpdq_pkg::PrioW-1:0]    job_priority_i,
  input  logic [mpdq_pkg::SvcW-1:0]     job_services_i,
  input  logic [mpdq_pkg::TagW-1:0]     job_tag_i,
  input  logic [mpdq_pkg::SvcIdxW-1:0]  service_index_i,
  output logic [mpdq_pkg::StatusW-1:0]  status_o,
  output logic [mpdq_pkg::TagW-1:0]     out_tag_o,
  output logic [mpdq_pkg::PrioW-1:0]    out_priority_o,
  output logic [mpdq_pkg::SvcW-1:0]     out_services_o,
  output logic [LvlW-1:0]               queue_level_o
);
  import mpdq_pkg::*;

  localparam logic [LvlW-1:0] Full = LvlW'(QUEUE_DEPTH);

  logic [PrioW-1:0] slot_prio_q [QUEUE_DEPTH];
  logic [SvcW-1:0]  slot_svc_q  [QUEUE_DEPTH];
  logic [TagW-1:0]  slot_tag_q  [QUEUE_DEPTH];
  logic [LvlW-1:0]  count_q;

  // latched request
  logic             req_q;
  logic [PrioW-1:0] prio_q;
  logic [SvcW-1:0]  svc_q;
  logic [TagW-1:0]  tag_q;

  // ge: slot priority >= new priority (a prefix, slots are sorted)
  // upto: inclusive prefix OR of service matches
  logic [QUEUE_DEPTH-1:0] ge_d, ge_q, upto_d, upto_q, match;
  logic                   svc_ok;

  status_e          status_q;
  logic [TagW-1:0]  otag_q;
  logic [PrioW-1:0] oprio_q;
  logic [SvcW-1:0]  osvc_q;

  logic             full, found;
  logic [QUEUE_DEPTH-1:0] first;
  logic [TagW-1:0]  sel_tag;
  logic [PrioW-1:0] sel_prio;
  logic [SvcW-1:0]  sel_svc;

  assign svc_ok = (service_index_i < SvcIdxW'(NumServices));

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge_d[i]  = (LvlW'(i) < count_q) && (slot_prio_q[i] >= job_priority_i);
      match[i] = (LvlW'(i) < count_q) && svc_ok &&
                 slot_svc_q[i][service_index_i];
    end
    upto_d[0] = match[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) upto_d[i] = upto_d[i-1] | match[i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      prio_q <= job_priority_i;
      svc_q  <= job_services_i;
      tag_q  <= job_tag_i;
      ge_q   <= ge_d;
      upto_q <= upto_d;
    end
  end

  assign full  = (count_q == Full);
  assign found = upto_q[QUEUE_DEPTH-1];

  // one-hot first match and its fields
  always_comb begin
    first[0] = upto_q[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) first[i] = upto_q[i] & ~upto_q[i-1];
    sel_tag  = '0;
    sel_prio = '0;
    sel_svc  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_tag  |= {TagW{first[i]}}  & slot_tag_q[i];
      sel_prio |= {PrioW{first[i]}} & slot_prio_q[i];
      sel_svc  |= {SvcW{first[i]}}  & slot_svc_q[i];
    end
  end

  // slot row: insert shifts toward the tail, remove shifts toward the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (req_q == ReqEnqueue) begin
          if (!full && !ge_q[i]) begin
            if (i == 0 || ge_q[(i == 0) ? 0 : i-1]) begin
              slot_prio_q[i] <= prio_q;
              slot_svc_q[i]  <= svc_q;
              slot_tag_q[i]  <= tag_q;
            end else begin
              slot_prio_q[i] <= slot_prio_q[(i == 0) ? 0 : i-1];
              slot_svc_q[i]  <= slot_svc_q[(i == 0) ? 0 : i-1];
              slot_tag_q[i]  <= slot_tag_q[(i == 0) ? 0 : i-1];
            end
          end
        end else if (upto_q[i] && i < QUEUE_DEPTH - 1) begin
          slot_prio_q[i] <= slot_prio_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
          slot_svc_q[i]  <= slot_svc_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
          slot_tag_q[i]  <= slot_tag_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      if (req_q == ReqEnqueue) begin
        if (!full) count_q <= count_q + LvlW'(1);
      end else if (found) begin
        count_q <= count_q - LvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (req_q == ReqEnqueue) begin
        status_q <= full ? ST_FULL : ST_QUEUED;
        otag_q   <= '0;
        oprio_q  <= '0;
        osvc_q   <= '0;
      end else if (found) begin
        status_q <= ST_DISPATCHED;
        otag_q   <= sel_tag;
        oprio_q  <= sel_prio;
        osvc_q   <= sel_svc;
      end else begin
        status_q <= ST_NO_MATCH;
        otag_q   <= '0;
        oprio_q  <= '0;
        osvc_q   <= '0;
      end
    end
  end

  assign status_o       = status_q;
  assign out_tag_o      = otag_q;
  assign out_priority_o = oprio_q;
  assign out_services_o = osvc_q;
  assign queue_level_o  = count_q;

endmodule

### hdl/masked_priority_dispatch_queue.sv
// Top level of the masked priority dispatch queue: controller plus datapath.
// Depends on mpdq_pkg, mpdq_ctrl and mpdq_dpath.
`timescale 1ns / 1ps

// Usage
//  Request channel: drive req_type_i and the job / service fields with start
//    high; the transaction is taken at the rising edge where start is high
//    and busy is low. Enqueue uses the job fields, dispatch uses service_index_i.
//  Result channel: done_o is high for exactly one cycle with status_o,
//    out_tag_o, out_priority_o, out_services_o and queue_level_o. The
//    receiver cannot stall; the result must be sampled in that cycle.
//  Sequence: at the accept edge the request and the per-slot compare vectors
//    (priority >= new priority, and the prefix of service matches) are
//    registered; at the next edge the slot row shifts and the result and
//    done_o are registered. busy is high for the one execute cycle, and no
//    start is taken while it is high; a new start is taken in the cycle
//    that done_o is shown.
//  Queue order: highest priority first, arrival order within a priority.
//    A full queue drops an enqueued job (status full); an unknown service or
//    no matching job gives status no match.
//  Reset: rst_ni low empties the queue (level 0) and idles the controller.
//    Slot contents are not cleared; only the occupied slots are ever read.

module masked_priority_dispatch_queue #(
  parameter int unsigned QUEUE_DEPTH = mpdq_pkg::DefDepth,
  parameter int unsigned LvlW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [mpdq_pkg::PrioW-1:0]    job_priority_i,
  input  logic [mpdq_pkg::SvcW-1:0]     job_services_i,
  input  logic [mpdq_pkg::TagW-1:0]     job_tag_i,
  input  logic [mpdq_pkg::SvcIdxW-1:0]  service_index_i,
  output logic                          done_o,
  output logic [mpdq_pkg::StatusW-1:0]  status_o,
  output logic [mpdq_pkg::TagW-1:0]     out_tag_o,
  output logic [mpdq_pkg::PrioW-1:0]    out_priority_o,
  output logic [mpdq_pkg::SvcW-1:0]     out_services_o,
  output logic [LvlW-1:0]               queue_level_o
);
  import mpdq_pkg::*;

  cmd_t cmd;

  // sequencing: idle / execute
  mpdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // slot storage, compares, shifting and result registers
  mpdq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LvlW        (LvlW)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_type_i),
    .job_priority_i  (job_priority_i),
    .job_services_i  (job_services_i),
    .job_tag_i       (job_tag_i),
    .service_index_i (service_index_i),
    .status_o        (status_o),
    .out_tag_o       (out_tag_o),
    .out_priority_o  (out_priority_o),
    .out_services_o  (out_services_o),
    .queue_level_o   (queue_level_o)
  );

endmodule

### hdl/mpdq_checker.sv
// Port-level checks for the masked priority dispatch queue, bound to the top.
// Depends on mpdq_pkg and masked_priority_dispatch_queue.
`timescale 1ns / 1ps

module mpdq_checker #(
  parameter int unsigned QUEUE_DEPTH = mpdq_pkg::DefDepth,
  parameter int unsigned LvlW        = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [mpdq_pkg::StatusW-1:0] status_o,
  input logic [LvlW-1:0]              queue_level_o
);
  import mpdq_pkg::*;

  // every accepted transaction produces its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing two cycles after accept");

  // the result is never shown while a transaction is executing
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (queue_level_o <= LvlW'(QUEUE_DEPTH)))
    else $error("queue level above depth");

  // a queued job leaves the queue non-empty; a full drop leaves it full
  a_queued_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_QUEUED) |-> (queue_level_o != '0))
    else $error("queued but level is zero");

  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (queue_level_o == LvlW'(QUEUE_DEPTH)))
    else $error("dropped as full but queue not full");

endmodule

bind masked_priority_dispatch_queue mpdq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .LvlW        (LvlW)
) u_mpdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .queue_level_o (queue_level_o)
);

### sim/tb.sv
// Self-checking bench for masked_priority_dispatch_queue: a bench-side copy of the
// sorted job store predicts every result, and a checker compares each done_o strobe.
// Depends on mpdq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import mpdq_pkg::*;

  localparam int unsigned Depth = DefDepth;
  localparam int unsigned LvlW  = $clog2(Depth + 1);

  typedef struct packed {
    status_e          status;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
    logic [SvcW-1:0]  svcs;
    logic [LvlW-1:0]  level;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [PrioW-1:0]    job_priority_i;
  logic [SvcW-1:0]     job_services_i;
  logic [TagW-1:0]     job_tag_i;
  logic [SvcIdxW-1:0]  service_index_i;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [TagW-1:0]     out_tag_o;
  logic [PrioW-1:0]    out_priority_o;
  logic [SvcW-1:0]     out_services_o;
  logic [LvlW-1:0]     queue_level_o;

  // bench copy of the job store, kept in dispatch order from slot 0
  logic [PrioW-1:0] held_prio [Depth];
  logic [SvcW-1:0]  held_svcs [Depth];
  logic [TagW-1:0]  held_tag  [Depth];
  int unsigned      held_count;

  outcome_t expected_outcomes[$];
  int       error_count;
  int       idle_pct;

  masked_priority_dispatch_queue #(
    .QUEUE_DEPTH(Depth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .job_priority_i (job_priority_i),
    .job_services_i (job_services_i),
    .job_tag_i      (job_tag_i),
    .service_index_i(service_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_priority_o (out_priority_o),
    .out_services_o (out_services_o),
    .queue_level_o  (queue_level_o)
  );

  always #5 clk_i = ~clk_i;

  // Insertion goes behind every job of equal or higher priority; dispatch takes the
  // first job in store order whose mask holds the service bit.
  function automatic outcome_t predict_dispatch_queue(input logic kind,
                                                      input logic [PrioW-1:0] prio,
                                                      input logic [SvcW-1:0] svcs,
                                                      input logic [TagW-1:0] tag,
                                                      input logic [SvcIdxW-1:0] svc_idx);
    outcome_t res;
    int unsigned pos;
    int unsigned i;
    bit found;
    res = '0;
    if (kind == ReqEnqueue) begin
      if (held_count >= Depth) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] >= prio) pos++;
        for (i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_svcs[i] = held_svcs[i-1];
          held_tag[i]  = held_tag[i-1];
        end
        held_prio[pos] = prio;
        held_svcs[pos] = svcs;
        held_tag[pos]  = tag;
        held_count++;
        res.status = ST_QUEUED;
      end
    end else begin
      found = 1'b0;
      pos = 0;
      if (svc_idx < NumServices) begin
        for (i = 0; i < held_count && !found; i++) begin
          if (held_svcs[i][svc_idx]) begin
            found = 1'b1;
            pos = i;
          end
        end
      end
      if (found) begin
        res.tag  = held_tag[pos];
        res.prio = held_prio[pos];
        res.svcs = held_svcs[pos];
        for (i = pos; i + 1 < held_count; i++) begin
          held_prio[i] = held_prio[i+1];
          held_svcs[i] = held_svcs[i+1];
          held_tag[i]  = held_tag[i+1];
        end
        held_count--;
        res.status = ST_DISPATCHED;
      end else begin
        res.status = ST_NO_MATCH;
      end
    end
    res.level = LvlW'(held_count);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with start
  // left high, so back-to-back transactions need no extra assignment.
  task automatic send_request(input logic kind, input logic [PrioW-1:0] prio,
                              input logic [SvcW-1:0] svcs, input logic [TagW-1:0] tag,
                              input logic [SvcIdxW-1:0] svc_idx);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_type_i      <= kind;
    job_priority_i  <= prio;
    job_services_i  <= svcs;
    job_tag_i       <= tag;
    service_index_i <= svc_idx;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    expected_outcomes.push_back(predict_dispatch_queue(kind, prio, svcs, tag, svc_idx));
    @(negedge clk_i);
  endtask

  // sender holds off until every outstanding transaction has reported back
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Corner cases: empty queue, unknown services, field extremes, ties, overflow.
  task automatic test_directed();
    int unsigned i;
    idle_pct = 0;
    send_request(ReqDispatch, 3'd7, 5'd31, 6'd63, 3'd0);  // nothing stored
    send_request(ReqEnqueue, 3'd0, 5'd0, 6'd0, 3'd7);     // empty mask, never served
    send_request(ReqEnqueue, 3'd7, 5'd31, 6'd63, 3'd0);
    send_request(ReqDispatch, 3'd0, 5'd0, 6'd0, 3'd7);    // beyond the last service
    send_request(ReqDispatch, 3'd5, 5'd21, 6'd42, 3'd5);
    send_request(ReqDispatch, 3'd0, 5'd0, 6'd0, 3'd4);
    // priorities that repeat across the fill check arrival order within a priority
    for (i = 0; i < Depth - 1; i++)
      send_request(ReqEnqueue, PrioW'(i % 4), SvcW'(1 << (i % NumServices)),
                   TagW'(i + 1), SvcIdxW'(i % 8));
    send_request(ReqEnqueue, 3'd7, 5'd31, 6'd42, 3'd2);   // store full, dropped
    for (i = 0; i < NumServices; i++)
      send_request(ReqDispatch, 3'd7, 5'd31, 6'd63, SvcIdxW'(i));
  endtask

  // Random traffic in segments whose enqueue share swings the level between empty
  // and full; with mixed set, idling switches on and off per segment.
  task automatic test_random_traffic(input int pct, input bit mixed, input int unsigned n);
    int unsigned k;
    int unsigned enq_share;
    logic kind;
    logic [PrioW-1:0] prio;
    logic [SvcW-1:0] svcs;
    logic [SvcIdxW-1:0] svc_idx;
    idle_pct  = pct;
    enq_share = 50;
    for (k = 0; k < n; k++) begin
      if (k % 24 == 0) begin
        enq_share = $urandom_range(85, 15);
        if (mixed) idle_pct = ($urandom_range(1) != 0) ? pct : 0;
      end
      kind = ($urandom_range(99) < enq_share) ? ReqEnqueue : ReqDispatch;
      prio = ($urandom_range(3) == 0) ? PrioW'($urandom_range(7))
                                      : PrioW'($urandom_range(4, 2));
      svcs = ($urandom_range(2) == 0) ? SvcW'(1 << $urandom_range(NumServices - 1))
                                      : SvcW'($urandom);
      svc_idx = ($urandom_range(9) == 0) ? SvcIdxW'($urandom_range(7, NumServices))
                                         : SvcIdxW'($urandom_range(NumServices - 1));
      send_request(kind, prio, svcs, TagW'($urandom), svc_idx);
    end
  endtask

  // each strobe is a completed transaction, taken at the edge ending its cycle
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d tag %0d level %0d",
               status_o, out_tag_o, queue_level_o);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (out_tag_o !== want.tag) begin
          $error("out_tag: expected %0d, got %0d", want.tag, out_tag_o);
          error_count++;
        end
        if (out_priority_o !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, out_priority_o);
          error_count++;
        end
        if (out_services_o !== want.svcs) begin
          $error("out_services: expected %0d, got %0d", want.svcs, out_services_o);
          error_count++;
        end
        if (queue_level_o !== want.level) begin
          $error("queue_level: expected %0d, got %0d", want.level, queue_level_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned spins;
    error_count     = 0;
    idle_pct        = 0;
    held_count      = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = ReqEnqueue;
    job_priority_i  = '0;
    job_services_i  = '0;
    job_tag_i       = '0;
    service_index_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    wait_drained();
    test_random_traffic(0, 1'b0, 130);
    wait_drained();
    test_random_traffic(63, 1'b0, 130);
    wait_drained();
    test_random_traffic(18, 1'b0, 130);
    wait_drained();
    test_random_traffic(63, 1'b1, 135);

    start <= 1'b0;
    spins = 0;
    while (expected_outcomes.size() != 0 && spins < 200) begin
      @(posedge clk_i);
      spins++;
    end
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      error_count++;
    end
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
